FILE: hdl/cst_pkg.sv
// Shared types, constants and character helpers for the C-subset token scanner.
// Used by cst_scanner, cst_result_fifo and c_subset_token_scanner.
`default_nettype none

package cst_pkg;

  // sizing
  localparam int MAX_VALUE_LEN = 255;
  localparam int LINE_BITS     = 16;
  localparam int KW_DEPTH      = 6;
  localparam int KW_COUNT      = 8;
  localparam int KW_IDX_W      = $clog2(KW_DEPTH);
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

  typedef logic [7:0] byte_t;
  typedef logic [LINE_BITS-1:0] line_t;
  typedef byte_t [KW_DEPTH-1:0] kw_window_t;

  // scanner modes
  typedef enum logic [3:0] {
    M_IDLE, M_NUM, M_IDENT, M_STR, M_EQ, M_BANG, M_SLASH, M_LCOM, M_BCOM, M_BSTAR
  } mode_t;

  // token codes
  localparam logic [4:0] T_IDENT   = 5'd8;
  localparam logic [4:0] T_NUMBER  = 5'd9;
  localparam logic [4:0] T_STRING  = 5'd10;
  localparam logic [4:0] T_PLUS    = 5'd11;
  localparam logic [4:0] T_MINUS   = 5'd12;
  localparam logic [4:0] T_STAR    = 5'd13;
  localparam logic [4:0] T_SLASH   = 5'd14;
  localparam logic [4:0] T_EQ      = 5'd15;
  localparam logic [4:0] T_EQEQ    = 5'd16;
  localparam logic [4:0] T_NEQ     = 5'd17;
  localparam logic [4:0] T_LT      = 5'd18;
  localparam logic [4:0] T_GT      = 5'd19;
  localparam logic [4:0] T_LPAREN  = 5'd20;
  localparam logic [4:0] T_RPAREN  = 5'd21;
  localparam logic [4:0] T_LBRACE  = 5'd22;
  localparam logic [4:0] T_RBRACE  = 5'd23;
  localparam logic [4:0] T_SEMI    = 5'd24;
  localparam logic [4:0] T_COMMA   = 5'd25;
  localparam logic [4:0] T_AMP     = 5'd26;
  localparam logic [4:0] T_EOF     = 5'd27;
  localparam logic [4:0] T_UNKNOWN = 5'd28;

  // record kinds
  localparam logic KIND_VALUE  = 1'b0;
  localparam logic KIND_RECORD = 1'b1;

  // characters with a role of their own
  localparam byte_t CH_NUL   = 8'h00;
  localparam byte_t CH_NL    = 8'h0a;
  localparam byte_t CH_QUOTE = 8'h22;
  localparam byte_t CH_BANG  = 8'h21;
  localparam byte_t CH_STAR  = 8'h2a;
  localparam byte_t CH_SLASH = 8'h2f;
  localparam byte_t CH_EQ    = 8'h3d;
  localparam byte_t CH_UNDER = 8'h5f;

  localparam line_t LINE_ONE = LINE_BITS'(1);
  localparam line_t LINE_MAX = '1;

  // keyword spellings, padded with zero bytes
  localparam byte_t KW_TEXT [KW_COUNT][KW_DEPTH] = '{
    '{"i", "n", "t", 8'd0, 8'd0, 8'd0},
    '{"c", "h", "a", "r", 8'd0, 8'd0},
    '{"v", "o", "i", "d", 8'd0, 8'd0},
    '{"r", "e", "t", "u", "r", "n"},
    '{"i", "f", 8'd0, 8'd0, 8'd0, 8'd0},
    '{"e", "l", "s", "e", 8'd0, 8'd0},
    '{"w", "h", "i", "l", "e", 8'd0},
    '{"f", "o", "r", 8'd0, 8'd0, 8'd0}
  };
  localparam byte_t KW_LEN [KW_COUNT] = '{8'd3, 8'd4, 8'd4, 8'd6, 8'd2, 8'd4, 8'd5, 8'd3};

  // one result as it travels to the output
  typedef struct packed {
    logic       kind;
    byte_t      vb;
    logic [4:0] ttype;
    logic [15:0] line;
    byte_t      len;
    logic       last;
  } result_t;

  function automatic logic is_digit(input byte_t c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(input byte_t c);
    return c inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_space(input byte_t c);
    return c inside {8'h20, [8'h09:8'h0d]};
  endfunction

  // low 16 bits of a line count
  function automatic logic [15:0] line16(input line_t l);
    logic [31:0] wide;
    wide = 32'(l);
    return wide[15:0];
  endfunction

  // saturating increment of the line count
  function automatic line_t line_bump(input line_t l);
    return (l == LINE_MAX) ? l : l + LINE_ONE;
  endfunction

  function automatic logic [4:0] single_type(input byte_t c);
    logic [4:0] t;
    case (c)
      "+":     t = T_PLUS;
      "-":     t = T_MINUS;
      "*":     t = T_STAR;
      "<":     t = T_LT;
      ">":     t = T_GT;
      "(":     t = T_LPAREN;
      ")":     t = T_RPAREN;
      "{":     t = T_LBRACE;
      "}":     t = T_RBRACE;
      ";":     t = T_SEMI;
      ",":     t = T_COMMA;
      "&":     t = T_AMP;
      default: t = T_UNKNOWN;
    endcase
    return t;
  endfunction

  // keyword lookup on the first bytes of an identifier, exact length only
  function automatic logic [4:0] ident_type(input kw_window_t win, input byte_t len);
    logic [4:0] t;
    logic       same;
    t = T_IDENT;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      same = (len == KW_LEN[k]);
      for (int i = 0; i < KW_DEPTH; i++) begin
        if ((8'(i) < KW_LEN[k]) && (win[i] != KW_TEXT[k][i])) begin
          same = 1'b0;
        end
      end
      if (same) begin
        t = 5'(k);
      end
    end
    return t;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/cst_scanner.sv
// Scanner state and per-byte token logic: up to two results per source byte.
// Depends on cst_pkg.
`default_nettype none

module cst_scanner
  import cst_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         fire,
  input  wire byte_t        c,
  output logic [1:0]        push_count,
  output result_t [1:0]     push_data
);

  mode_t      mode, mode_next;
  line_t      line_count, line_next;
  line_t      start_line, sline_next;
  byte_t      vlen, vlen_next;
  kw_window_t win, win_next;
  byte_t      first_char, first_next;

  logic    flush_ok, use_flush, tail_ok, do_start, do_accept;
  result_t flush_rec, tail_rec;

  // next state and results for the current byte
  always_comb begin
    mode_next  = mode;
    line_next  = line_count;
    sline_next = start_line;
    vlen_next  = vlen;
    win_next   = win;
    first_next = first_char;
    flush_ok   = 1'b0;
    use_flush  = 1'b0;
    tail_ok    = 1'b0;
    do_start   = 1'b0;
    do_accept  = 1'b0;
    tail_rec   = '0;

    // record for a pending token
    flush_rec       = '0;
    flush_rec.kind  = KIND_RECORD;
    flush_rec.line  = line16(start_line);
    flush_rec.vb    = first_char;
    flush_rec.len   = vlen;
    case (mode)
      M_NUM: begin
        flush_ok        = 1'b1;
        flush_rec.ttype = T_NUMBER;
      end
      M_IDENT: begin
        flush_ok        = 1'b1;
        flush_rec.ttype = ident_type(win, vlen);
      end
      M_STR: begin
        flush_ok        = 1'b1;
        flush_rec.ttype = T_STRING;
      end
      M_EQ: begin
        flush_ok        = 1'b1;
        flush_rec.ttype = T_EQ;
        flush_rec.vb    = CH_EQ;
        flush_rec.len   = 8'd1;
      end
      M_BANG: begin
        flush_ok        = 1'b1;
        flush_rec.ttype = T_UNKNOWN;
        flush_rec.vb    = CH_BANG;
        flush_rec.len   = 8'd1;
      end
      M_SLASH: begin
        flush_ok        = 1'b1;
        flush_rec.ttype = T_SLASH;
        flush_rec.vb    = CH_SLASH;
        flush_rec.len   = 8'd1;
      end
      default: flush_ok = 1'b0;
    endcase

    // mode dispatch
    if (c == CH_NUL) begin
      use_flush      = flush_ok;
      tail_ok        = 1'b1;
      tail_rec.kind  = KIND_RECORD;
      tail_rec.ttype = T_EOF;
      tail_rec.line  = line16(line_count);
      mode_next      = M_IDLE;
      line_next      = LINE_ONE;
      sline_next     = LINE_ONE;
      vlen_next      = '0;
    end else begin
      case (mode)
        M_NUM: begin
          if (is_digit(c)) begin
            do_accept = 1'b1;
          end else begin
            use_flush = flush_ok;
            do_start  = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
            do_accept = 1'b1;
          end else begin
            use_flush = flush_ok;
            do_start  = 1'b1;
          end
        end
        M_STR: begin
          if (c == CH_QUOTE) begin
            use_flush = flush_ok;
            mode_next = M_IDLE;
          end else begin
            if (c == CH_NL) begin
              line_next = line_bump(line_count);
            end
            do_accept = 1'b1;
          end
        end
        M_EQ, M_BANG: begin
          if (c == CH_EQ) begin
            tail_ok        = 1'b1;
            tail_rec.kind  = KIND_RECORD;
            tail_rec.ttype = (mode == M_EQ) ? T_EQEQ : T_NEQ;
            tail_rec.vb    = (mode == M_EQ) ? CH_EQ : CH_BANG;
            tail_rec.line  = line16(start_line);
            tail_rec.len   = 8'd2;
            mode_next      = M_IDLE;
          end else begin
            use_flush = flush_ok;
            do_start  = 1'b1;
          end
        end
        M_SLASH: begin
          if (c == CH_SLASH) begin
            mode_next = M_LCOM;
          end else if (c == CH_STAR) begin
            mode_next = M_BCOM;
          end else begin
            use_flush = flush_ok;
            do_start  = 1'b1;
          end
        end
        M_LCOM: begin
          if (c == CH_NL) begin
            line_next = line_bump(line_count);
            mode_next = M_IDLE;
          end
        end
        M_BCOM, M_BSTAR: begin
          if (c == CH_NL) begin
            line_next = line_bump(line_count);
          end
          if (mode == M_BSTAR && c == CH_SLASH) begin
            mode_next = M_IDLE;
          end else begin
            mode_next = (c == CH_STAR) ? M_BSTAR : M_BCOM;
          end
        end
        default: do_start = 1'b1;
      endcase
    end

    // start a new token with the current byte, or skip it if it is white space
    if (do_start) begin
      mode_next = M_IDLE;
      if (is_space(c)) begin
        if (c == CH_NL) begin
          line_next = line_bump(line_count);
        end
      end else begin
        sline_next = line_count;
        vlen_next  = '0;
        first_next = c;
        if (is_digit(c)) begin
          mode_next = M_NUM;
          do_accept = 1'b1;
        end else if (is_alpha(c) || c == CH_UNDER) begin
          mode_next = M_IDENT;
          do_accept = 1'b1;
        end else if (c == CH_QUOTE) begin
          mode_next  = M_STR;
          first_next = '0;
        end else if (c == CH_EQ) begin
          mode_next = M_EQ;
        end else if (c == CH_BANG) begin
          mode_next = M_BANG;
        end else if (c == CH_SLASH) begin
          mode_next = M_SLASH;
        end else begin
          tail_ok        = 1'b1;
          tail_rec.kind  = KIND_RECORD;
          tail_rec.ttype = single_type(c);
          tail_rec.vb    = c;
          tail_rec.line  = line16(line_count);
          tail_rec.len   = 8'd1;
        end
      end
    end

    // value byte, dropped once the length saturates
    if (do_accept && vlen_next < 8'(MAX_VALUE_LEN)) begin
      if (vlen_next == '0) begin
        first_next = c;
      end
      if (vlen_next < 8'(KW_DEPTH)) begin
        win_next[vlen_next[KW_IDX_W-1:0]] = c;
      end
      vlen_next     = vlen_next + 8'd1;
      tail_ok       = 1'b1;
      tail_rec      = '0;
      tail_rec.kind = KIND_VALUE;
      tail_rec.vb   = c;
    end
  end

  // pack the results and mark the last one
  always_comb begin
    push_data = '0;
    if (use_flush) begin
      push_data[0]      = flush_rec;
      push_data[1]      = tail_rec;
      push_data[0].last = !tail_ok;
      push_data[1].last = 1'b1;
    end else begin
      push_data[0]      = tail_rec;
      push_data[0].last = 1'b1;
    end
    push_count = fire ? (2'(use_flush) + 2'(tail_ok)) : 2'd0;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      line_count <= LINE_ONE;
      start_line <= LINE_ONE;
      vlen       <= '0;
      win        <= '0;
      first_char <= '0;
    end else if (fire) begin
      mode       <= mode_next;
      line_count <= line_next;
      start_line <= sline_next;
      vlen       <= vlen_next;
      win        <= win_next;
      first_char <= first_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/cst_result_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per cycle while out_ready is high.
// Depends on cst_pkg.
`default_nettype none

module cst_result_fifo
  import cst_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [1:0]     push_count,
  input  wire result_t [1:0]  push_data,
  output logic                room2,
  output logic                out_valid,
  input  wire logic           out_ready,
  output result_t             out_data
);

  result_t entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic pop;

  // status and head
  always_comb begin
    out_valid = (count != '0);
    out_data  = entries[rd_ptr];
    pop       = out_valid && out_ready;
    room2     = (count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  end

  // storage writes
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push_data[0];
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr + FIFO_PTR_W'(1)] <= push_data[1];
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      count <= count + FIFO_CNT_W'(push_count) - FIFO_CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

FILE: hdl/c_subset_token_scanner.sv
// Top level of the C-subset token scanner: input register, scanner, result queue.
// Depends on cst_pkg, cst_scanner and cst_result_fifo.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+------------------------------------------
//   source   | source_valid / source_ready  | source_byte
//   result   | result_valid / result_ready  | record_kind value_byte token_type
//            |                              | token_line token_length last_of_item
//
// One source byte per clock while the queue has room: a byte waits in the input
// register, is scanned there and its zero to two results land in a four-entry
// queue. The queue drains one result per clock while result_ready is high, so
// bytes that yield two results drain more slowly than they are scanned; the
// scanner stalls only when the queue has less than two free entries. Synchronous
// reset puts the scanner idle, the line count at one and empties the queue.
`default_nettype none

module c_subset_token_scanner
  import cst_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        source_valid,
  output logic             source_ready,
  input  wire logic [7:0]  source_byte,
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic             record_kind,
  output logic [7:0]       value_byte,
  output logic [4:0]       token_type,
  output logic [15:0]      token_line,
  output logic [7:0]       token_length,
  output logic             last_of_item
);

  logic          held;
  byte_t         held_byte;
  logic          room2, fire;
  logic [1:0]    push_count;
  result_t [1:0] push_data;
  result_t       head;

  // input register handshake
  always_comb begin
    fire         = held && room2;
    source_ready = !held || fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (source_ready) begin
      held <= source_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (source_ready && source_valid) begin
      held_byte <= source_byte;
    end
  end

  cst_scanner u_scanner (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .c          (held_byte),
    .push_count (push_count),
    .push_data  (push_data)
  );

  cst_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push_data  (push_data),
    .room2      (room2),
    .out_valid  (result_valid),
    .out_ready  (result_ready),
    .out_data   (head)
  );

  // result fields
  always_comb begin
    record_kind  = head.kind;
    value_byte   = head.vb;
    token_type   = head.ttype;
    token_line   = head.line;
    token_length = head.len;
    last_of_item = head.last;
  end

endmodule

`default_nettype wire

FILE: tb/sv/token_stream_checker.sv
// Checker for the C-subset token scanner: watches both channels, predicts the
// result stream of every accepted source byte and compares it field by field.
// Depends on cst_pkg for the result layout, scanner modes and token codes.
`timescale 1ns / 1ps

module token_stream_checker
  import cst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        source_valid,
  input  logic        source_ready,
  input  logic [7:0]  source_byte,
  input  logic        result_valid,
  input  logic        result_ready,
  input  logic        record_kind,
  input  logic [7:0]  value_byte,
  input  logic [4:0]  token_type,
  input  logic [15:0] token_line,
  input  logic [7:0]  token_length,
  input  logic        last_of_item,
  output int          mismatch_count,
  output int          results_owed
);

  // keyword token codes
  localparam logic [4:0] T_KW_INT    = 5'd0;
  localparam logic [4:0] T_KW_CHAR   = 5'd1;
  localparam logic [4:0] T_KW_VOID   = 5'd2;
  localparam logic [4:0] T_KW_RETURN = 5'd3;
  localparam logic [4:0] T_KW_IF     = 5'd4;
  localparam logic [4:0] T_KW_ELSE   = 5'd5;
  localparam logic [4:0] T_KW_WHILE  = 5'd6;
  localparam logic [4:0] T_KW_FOR    = 5'd7;

  // scanner state as predicted
  mode_t scan_st;
  line_t cur_line;
  line_t tok_line;
  byte_t tok_len;
  byte_t head_char;
  byte_t kw_win [KW_DEPTH];

  result_t step_results [$];
  result_t pending_results [$];

  function automatic logic digit_ch(input byte_t c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic letter_ch(input byte_t c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic blank_ch(input byte_t c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic [4:0] op_code(input byte_t c);
    case (c)
      "+":     return T_PLUS;
      "-":     return T_MINUS;
      "*":     return T_STAR;
      "<":     return T_LT;
      ">":     return T_GT;
      "(":     return T_LPAREN;
      ")":     return T_RPAREN;
      "{":     return T_LBRACE;
      "}":     return T_RBRACE;
      ";":     return T_SEMI;
      ",":     return T_COMMA;
      "&":     return T_AMP;
      default: return T_UNKNOWN;
    endcase
  endfunction

  // keyword match needs the exact spelling and length
  function automatic logic [4:0] word_type();
    logic [47:0] w;
    w = '0;
    if (tok_len > KW_DEPTH) return T_IDENT;
    for (int i = 0; i < tok_len; i++) w = {w[39:0], kw_win[i]};
    case (w)
      "int":    return T_KW_INT;
      "char":   return T_KW_CHAR;
      "void":   return T_KW_VOID;
      "return": return T_KW_RETURN;
      "if":     return T_KW_IF;
      "else":   return T_KW_ELSE;
      "while":  return T_KW_WHILE;
      "for":    return T_KW_FOR;
      default:  return T_IDENT;
    endcase
  endfunction

  function automatic void add_result(input logic kind, input byte_t vb, input logic [4:0] tt,
                                     input line_t ln, input byte_t len);
    result_t r;
    r.kind  = kind;
    r.vb    = vb;
    r.ttype = tt;
    r.line  = ln[15:0];
    r.len   = len;
    r.last  = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void add_token(input logic [4:0] tt, input byte_t vb, input byte_t len);
    add_result(KIND_RECORD, vb, tt, tok_line, len);
  endfunction

  function automatic void bump_line();
    if (cur_line != LINE_MAX) cur_line = cur_line + LINE_ONE;
  endfunction

  // value byte of a number, identifier or string; dropped past the cap
  function automatic void take_value(input byte_t c);
    if (tok_len >= MAX_VALUE_LEN) return;
    if (tok_len == 0) head_char = c;
    if (tok_len < KW_DEPTH) kw_win[tok_len] = c;
    tok_len = tok_len + 8'd1;
    add_result(KIND_VALUE, c, 5'd0, '0, 8'd0);
  endfunction

  // close whatever token is open
  function automatic void flush_token();
    case (scan_st)
      M_NUM:   add_token(T_NUMBER, head_char, tok_len);
      M_IDENT: add_token(word_type(), head_char, tok_len);
      M_STR:   add_token(T_STRING, head_char, tok_len);
      M_EQ:    add_token(T_EQ, CH_EQ, 8'd1);
      M_BANG:  add_token(T_UNKNOWN, CH_BANG, 8'd1);
      M_SLASH: add_token(T_SLASH, CH_SLASH, 8'd1);
      default: ;
    endcase
  endfunction

  function automatic void begin_token(input byte_t c);
    scan_st = M_IDLE;
    if (blank_ch(c)) begin
      if (c == CH_NL) bump_line();
      return;
    end
    tok_line  = cur_line;
    tok_len   = 8'd0;
    head_char = c;
    if (digit_ch(c)) begin
      scan_st = M_NUM;
      take_value(c);
    end else if (letter_ch(c) || c == CH_UNDER) begin
      scan_st = M_IDENT;
      take_value(c);
    end else if (c == CH_QUOTE) begin
      scan_st   = M_STR;
      head_char = CH_NUL;
    end else if (c == CH_EQ) begin
      scan_st = M_EQ;
    end else if (c == CH_BANG) begin
      scan_st = M_BANG;
    end else if (c == CH_SLASH) begin
      scan_st = M_SLASH;
    end else begin
      add_token(op_code(c), c, 8'd1);
    end
  endfunction

  function automatic void scan_byte(input byte_t c);
    // end of input flushes, reports eof and restarts the line count
    if (c == CH_NUL) begin
      flush_token();
      add_result(KIND_RECORD, CH_NUL, T_EOF, cur_line, 8'd0);
      scan_st  = M_IDLE;
      cur_line = LINE_ONE;
      tok_line = LINE_ONE;
      tok_len  = 8'd0;
      return;
    end
    case (scan_st)
      M_NUM: begin
        if (digit_ch(c)) begin
          take_value(c);
          return;
        end
        flush_token();
      end
      M_IDENT: begin
        if (letter_ch(c) || digit_ch(c) || c == CH_UNDER) begin
          take_value(c);
          return;
        end
        flush_token();
      end
      M_STR: begin
        if (c == CH_QUOTE) begin
          flush_token();
          scan_st = M_IDLE;
          return;
        end
        if (c == CH_NL) bump_line();
        take_value(c);
        return;
      end
      M_EQ, M_BANG: begin
        if (c == CH_EQ) begin
          if (scan_st == M_EQ) add_token(T_EQEQ, CH_EQ, 8'd2);
          else add_token(T_NEQ, CH_BANG, 8'd2);
          scan_st = M_IDLE;
          return;
        end
        flush_token();
      end
      M_SLASH: begin
        if (c == CH_SLASH) begin
          scan_st = M_LCOM;
          return;
        end
        if (c == CH_STAR) begin
          scan_st = M_BCOM;
          return;
        end
        flush_token();
      end
      M_LCOM: begin
        if (c == CH_NL) begin
          bump_line();
          scan_st = M_IDLE;
        end
        return;
      end
      M_BCOM, M_BSTAR: begin
        if (c == CH_NL) bump_line();
        if (scan_st == M_BSTAR && c == CH_SLASH) scan_st = M_IDLE;
        else scan_st = (c == CH_STAR) ? M_BSTAR : M_BCOM;
        return;
      end
      default: ;
    endcase
    begin_token(c);
  endfunction

  // predict one request and queue its results in order
  task automatic predict_request(input byte_t c);
    step_results.delete();
    scan_byte(c);
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i]) pending_results.push_back(step_results[i]);
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_result();
    result_t want;
    if (pending_results.size() == 0) begin
      $error("result with nothing expected: kind %0d, type %0d, value %0d",
             record_kind, token_type, value_byte);
      mismatch_count++;
    end else begin
      want = pending_results.pop_front();
      compare_field("record_kind", want.kind, record_kind);
      compare_field("value_byte", want.vb, value_byte);
      compare_field("token_type", want.ttype, token_type);
      compare_field("token_line", want.line, token_line);
      compare_field("token_length", want.len, token_length);
      compare_field("last_of_item", want.last, last_of_item);
    end
  endtask

  // watch both channels
  always @(posedge clk) begin
    if (rst) begin
      scan_st   = M_IDLE;
      cur_line  = LINE_ONE;
      tok_line  = LINE_ONE;
      tok_len   = 8'd0;
      head_char = CH_NUL;
      foreach (kw_win[i]) kw_win[i] = CH_NUL;
      pending_results.delete();
      mismatch_count = 0;
    end else begin
      if (source_valid && source_ready) predict_request(source_byte);
      if (result_valid && result_ready) check_result();
    end
    results_owed <= pending_results.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
// Top of the token scanner testbench: clock, reset, source stimulus and the
// receiver's stalls; the verdict comes from token_stream_checker's counts.
// Depends on cst_pkg, c_subset_token_scanner and token_stream_checker.
`timescale 1ns / 1ps

module tb_top;
  import cst_pkg::*;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        source_valid = 1'b0;
  logic [7:0]  source_byte  = 8'd0;
  logic        result_ready = 1'b0;
  logic        source_ready;
  logic        result_valid;
  logic        record_kind;
  logic [7:0]  value_byte;
  logic [4:0]  token_type;
  logic [15:0] token_line;
  logic [7:0]  token_length;
  logic        last_of_item;

  int mismatch_count;
  int results_owed;
  int src_idle_pct = 0;
  int dst_idle_pct = 0;
  int bytes_sent   = 0;

  string kw_words [8] = '{"int", "char", "void", "return", "if", "else", "while", "for"};
  string op_chars     = "+-*/<>(){};,&=!";

  always #4 clk = ~clk;

  c_subset_token_scanner u_dut (
    .clk          (clk),
    .rst          (rst),
    .source_valid (source_valid),
    .source_ready (source_ready),
    .source_byte  (source_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .record_kind  (record_kind),
    .value_byte   (value_byte),
    .token_type   (token_type),
    .token_line   (token_line),
    .token_length (token_length),
    .last_of_item (last_of_item)
  );

  token_stream_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .source_valid   (source_valid),
    .source_ready   (source_ready),
    .source_byte    (source_byte),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .record_kind    (record_kind),
    .value_byte     (value_byte),
    .token_type     (token_type),
    .token_line     (token_line),
    .token_length   (token_length),
    .last_of_item   (last_of_item),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  // receiver stalls at random
  always @(posedge clk) begin
    result_ready <= ($urandom_range(0, 99) >= dst_idle_pct);
  end

  // drive one request on the source channel and wait for its acceptance
  task automatic push_char(input byte_t c);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      source_valid <= 1'b0;
      @(posedge clk);
    end
    source_valid <= 1'b1;
    source_byte  <= c;
    @(posedge clk);
    while (!source_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  // hold the source off until every predicted result has come out
  task automatic drain();
    source_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  function automatic byte_t rand_letter();
    int r;
    r = $urandom_range(0, 52);
    if (r == 52) return CH_UNDER;
    return (r < 26) ? byte_t'("a" + r) : byte_t'("A" + r - 26);
  endfunction

  function automatic byte_t rand_word_char();
    if ($urandom_range(0, 3) == 0) return byte_t'("0" + $urandom_range(0, 9));
    return rand_letter();
  endfunction

  // any byte that neither ends input nor closes a string
  function automatic byte_t rand_body_byte();
    byte_t b;
    do b = byte_t'($urandom_range(1, 255)); while (b == CH_QUOTE);
    return b;
  endfunction

  // one token of random shape, mostly well formed
  task automatic emit_token();
    byte_t chars [$];
    byte_t b;
    int    pick;
    int    k;
    int    n;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      k = $urandom_range(0, 7);
      for (int i = 0; i < kw_words[k].len(); i++) chars.push_back(kw_words[k][i]);
      n = $urandom_range(0, 7);
      if (n == 0) chars.push_back(rand_word_char());
      else if (n == 1) void'(chars.pop_back());
    end else if (pick < 30) begin
      chars.push_back(rand_letter());
      n = $urandom_range(0, 7);
      repeat (n) chars.push_back(rand_word_char());
    end else if (pick < 42) begin
      n = $urandom_range(1, 6);
      repeat (n) chars.push_back(byte_t'("0" + $urandom_range(0, 9)));
    end else if (pick < 52) begin
      chars.push_back(CH_QUOTE);
      n = $urandom_range(0, 6);
      repeat (n) chars.push_back(($urandom_range(0, 4) == 0) ? CH_NL : rand_body_byte());
      if ($urandom_range(0, 9) != 0) chars.push_back(CH_QUOTE);
    end else if (pick < 72) begin
      n = $urandom_range(0, op_chars.len() + 1);
      if (n == op_chars.len()) begin
        chars.push_back(CH_EQ);
        chars.push_back(CH_EQ);
      end else if (n > op_chars.len()) begin
        chars.push_back(CH_BANG);
        chars.push_back(CH_EQ);
      end else begin
        chars.push_back(op_chars[n]);
      end
    end else if (pick < 78) begin
      chars.push_back(CH_SLASH);
      chars.push_back(CH_SLASH);
      n = $urandom_range(0, 5);
      repeat (n) begin
        do b = byte_t'($urandom_range(1, 255)); while (b == CH_NL);
        chars.push_back(b);
      end
      chars.push_back(CH_NL);
    end else if (pick < 86) begin
      chars.push_back(CH_SLASH);
      chars.push_back(CH_STAR);
      n = $urandom_range(0, 6);
      repeat (n) begin
        case ($urandom_range(0, 4))
          0:       chars.push_back(CH_STAR);
          1:       chars.push_back(CH_SLASH);
          2:       chars.push_back(CH_NL);
          default: chars.push_back(rand_body_byte());
        endcase
      end
      if ($urandom_range(0, 9) != 0) begin
        chars.push_back(CH_STAR);
        chars.push_back(CH_SLASH);
      end
    end else if (pick < 94) begin
      n = $urandom_range(1, 3);
      repeat (n) chars.push_back(byte_t'($urandom_range(9, 13)));
      chars.push_back(" ");
    end else if (pick < 98) begin
      chars.push_back(byte_t'($urandom_range(1, 255)));
    end else begin
      chars.push_back(CH_NUL);
    end
    // separator or none, so tokens also abut
    case ($urandom_range(0, 3))
      0:       chars.push_back(" ");
      1:       chars.push_back(CH_NL);
      default: ;
    endcase
    foreach (chars[i]) push_char(chars[i]);
  endtask

  task automatic random_stream(input int count);
    int start_count;
    start_count = bytes_sent;
    while (bytes_sent - start_count < count) emit_token();
  endtask

  // values past the length cap
  task automatic long_values();
    push_char("w");
    repeat (259) push_char(rand_word_char());
    push_char(" ");
    repeat (260) push_char(byte_t'("0" + $urandom_range(0, 9)));
    push_char(CH_QUOTE);
    repeat (260) push_char(rand_body_byte());
    push_char(CH_QUOTE);
    push_text("return1 ");
  endtask

  // newlines inside strings and comments, held operator flushed at end of input
  task automatic line_mix();
    push_text("x");
    repeat (3) push_char(CH_NL);
    push_text("y \"\n\" /*\n*/ =");
    push_char(CH_NUL);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // sender idles about a third of the time, receiver more than half
    src_idle_pct = 36;
    dst_idle_pct <= 56;
    push_text("a1 42==!=!x=/y//c\n/*/*/\"\n\"@");
    push_char(8'hff);
    push_char(8'h80);
    push_text("\"q");
    push_char(CH_NUL);
    random_stream(360);
    push_char(CH_NUL);
    drain();

    src_idle_pct = 56;
    dst_idle_pct <= 36;
    random_stream(360);
    push_char(CH_NUL);
    drain();

    // no idling on either side
    src_idle_pct = 0;
    dst_idle_pct <= 0;
    long_values();
    push_char(CH_NUL);
    line_mix();
    random_stream(360);
    push_char(CH_NUL);

    drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: sim.f
hdl/cst_pkg.sv
hdl/cst_scanner.sv
hdl/cst_result_fifo.sv
hdl/c_subset_token_scanner.sv
tb/sv/token_stream_checker.sv
tb/sv/tb_top.sv
